// ----- src/cbt_pkg.sv -----
// Shared types and constants for the circuit breaker table.
package cbt_pkg;

  localparam int FUNC_W          = 2;
  localparam int IDX_W           = 4;
  localparam int COUNT_W         = 8;
  localparam int TIME_W          = 32;
  localparam int LIMIT_W         = 8;
  localparam int WAIT_W          = 24;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_IDX_W       = 1;
  localparam int DEF_SERVER_COUNT = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);
  localparam logic [WAIT_W-1:0]  WAIT_RESET  = WAIT_W'(30000);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_SUCCESS = 2'd1,
    FUNC_FAILURE = 2'd2,
    FUNC_TICK    = 2'd3
  } cbt_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAILURE_LIMIT = 1'b0,
    REG_RECOVERY_WAIT = 1'b1
  } cbt_reg_t;

  typedef struct packed {
    logic               open;
    logic               probe;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  opened;
  } cbt_entry_t;

endpackage

// ----- src/cbt_update.sv -----
// Next-state logic for one breaker entry and the request decision.
module cbt_update (
  input  cbt_pkg::cbt_func_t               func,
  input  cbt_pkg::cbt_entry_t              cur,
  input  logic [cbt_pkg::TIME_W-1:0]       now_ms,
  input  logic [cbt_pkg::LIMIT_W-1:0]      failure_limit,
  input  logic [cbt_pkg::WAIT_W-1:0]       recovery_wait_ms,
  output cbt_pkg::cbt_entry_t              nxt,
  output logic                             allowed
);
  import cbt_pkg::*;

  logic [TIME_W-1:0]  elapsed;
  logic               waited;
  logic [COUNT_W-1:0] count_inc;
  logic [LIMIT_W-1:0] limit_eff;

  // Elapsed time wraps with the timer, so a plain modular subtract is right.
  assign elapsed   = now_ms - cur.opened;
  assign waited    = elapsed >= {{(TIME_W-WAIT_W){1'b0}}, recovery_wait_ms};
  assign count_inc = (cur.count == COUNT_MAX) ? COUNT_MAX : cur.count + COUNT_W'(1);
  assign limit_eff = (failure_limit == '0) ? LIMIT_W'(1) : failure_limit;

  always_comb begin
    nxt     = cur;
    allowed = 1'b0;
    unique case (func)
      FUNC_REQUEST: begin
        if (!cur.open) begin
          allowed = 1'b1;
        end else if (waited && !cur.probe) begin
          nxt.probe = 1'b1;
          allowed   = 1'b1;
        end
      end
      FUNC_SUCCESS: begin
        nxt.open  = 1'b0;
        nxt.probe = 1'b0;
        nxt.count = '0;
      end
      FUNC_FAILURE: begin
        nxt.probe = 1'b0;
        nxt.count = count_inc;
        if (count_inc >= limit_eff) begin
          nxt.open   = 1'b1;
          nxt.opened = now_ms;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ----- src/circuit_breaker_table.sv -----
// Top level of the circuit breaker table: request pipeline, entry table and timer.
//
// Usage: each request on the input channel carries a function code and a server
// index. A query asks whether a call to that server may proceed; success and
// failure reports update the server's breaker entry; a tick advances the
// millisecond timer. Every request produces exactly one result on the output
// channel with the allow decision and the entry's state after the update.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. The request is captured in an input register and the entry update
// is done on the way into the result register. Throughput is one request per
// cycle while the receiver does not stall, set by the single read-modify-write
// of the addressed entry between the two registers. When the receiver stalls,
// the result register holds and the input register still takes one more
// request before in_stall rises. A synchronous active-low reset clears all
// entries, the timer and the valid bits of both pipeline registers and restores
// the configuration defaults. The user writes configuration through
// cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module circuit_breaker_table #(
  parameter int SERVER_COUNT = cbt_pkg::DEF_SERVER_COUNT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port.
  input  logic                               cfg_wr_en,
  input  logic [cbt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Request channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cbt_pkg::FUNC_W-1:0]         in_func,
  input  logic [cbt_pkg::IDX_W-1:0]          in_server_index,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_allowed,
  output logic                               out_circuit_open,
  output logic                               out_probe_pending,
  output logic [cbt_pkg::COUNT_W-1:0]        out_failure_count
);
  import cbt_pkg::*;

  // The index field can only reach the first 2**IDX_W entries, so the table
  // never holds more than that even for a larger server count.
  localparam int ENTRIES = (SERVER_COUNT < (1 << IDX_W)) ? SERVER_COUNT : (1 << IDX_W);
  localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W:0] ENTRIES_V = (IDX_W+1)'(ENTRIES);

  // Configuration registers.
  logic [LIMIT_W-1:0] failure_limit_r;
  logic [WAIT_W-1:0]  recovery_wait_r;

  // Breaker state.
  cbt_entry_t         tbl_r [ENTRIES];
  logic [TIME_W-1:0]  now_r;

  // Input register.
  logic               s1_valid_r;
  logic [FUNC_W-1:0]  s1_func_r;
  logic [IDX_W-1:0]   s1_idx_r;

  // Result register.
  logic               out_valid_r;
  logic               out_allowed_r;
  logic               out_open_r;
  logic               out_probe_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               advance;
  logic               in_accept;
  cbt_func_t          s1_func;
  logic               in_range;
  logic               is_tick;
  logic               touches_entry;
  logic [EW-1:0]      entry_sel;
  cbt_entry_t         cur_entry;
  cbt_entry_t         nxt_entry;
  logic               upd_allowed;

  // The input register empties whenever the result register is free or drains.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign s1_func       = cbt_func_t'(s1_func_r);
  assign is_tick       = (s1_func == FUNC_TICK);
  assign in_range      = {1'b0, s1_idx_r} < ENTRIES_V;
  assign touches_entry = !is_tick && in_range;
  // Out-of-range indexes are steered to entry zero; their update is discarded.
  assign entry_sel     = in_range ? s1_idx_r[EW-1:0] : '0;
  assign cur_entry     = tbl_r[entry_sel];

  cbt_update u_update (
    .func             (s1_func),
    .cur              (cur_entry),
    .now_ms           (now_r),
    .failure_limit    (failure_limit_r),
    .recovery_wait_ms (recovery_wait_r),
    .nxt              (nxt_entry),
    .allowed          (upd_allowed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failure_limit_r <= LIMIT_RESET;
      recovery_wait_r <= WAIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cbt_reg_t'(cfg_index))
        REG_FAILURE_LIMIT: failure_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_RECOVERY_WAIT: recovery_wait_r <= cfg_wdata[WAIT_W-1:0];
        default:           failure_limit_r <= failure_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r <= in_func;
      s1_idx_r  <= in_server_index;
    end
  end

  // State update happens as the request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_r[i] <= '0;
      end
      now_r <= '0;
    end else if (advance) begin
      if (is_tick) begin
        now_r <= now_r + TIME_W'(1);
      end else if (in_range) begin
        tbl_r[entry_sel] <= nxt_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Ticks and out-of-range requests report all fields as zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_allowed_r <= touches_entry && upd_allowed;
      out_open_r    <= touches_entry && nxt_entry.open;
      out_probe_r   <= touches_entry && nxt_entry.probe;
      out_count_r   <= touches_entry ? nxt_entry.count : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_allowed       = out_allowed_r;
  assign out_circuit_open  = out_open_r;
  assign out_probe_pending = out_probe_r;
  assign out_failure_count = out_count_r;

  // A probe can only be outstanding on an open circuit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_probe_r |-> out_open_r)
    else $error("probe pending on a closed circuit");

  // Letting a request through an open circuit must mark the probe.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_allowed_r && out_open_r |-> out_probe_r)
    else $error("open circuit allowed a request without a probe");

  // A circuit opens only after at least one counted failure.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_open_r |-> (out_count_r != '0))
    else $error("open circuit with zero failure count");

  // An empty input register never pushes back on the sender.
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("stall raised with an empty input register");

endmodule
